// ===== src/pth_pkg.sv =====
`default_nettype none

package pth_pkg;

    // Input operation codes, as they arrive in s_tuser
    localparam logic [1:0] OP_PULSE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_GAP_TICKS = 1'b0;
    localparam logic [0:0] REG_BAND      = 1'b1;

    // Serial command codes
    localparam logic [7:0] RX_ARM_CODE   = 8'hAA;
    localparam logic [7:0] RX_REPLY_CODE = 8'h00;

    // Reset values of the configuration registers
    localparam logic [15:0] GAP_TICKS_RESET = 16'd50;
    localparam logic [7:0]  BAND_RESET      = 8'd8;

    // Celsius conversion offset, in counts
    localparam int CEL_OFFSET = 801;

    // Entries of the front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PULSE = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_BYTE  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== src/pth_front.sv =====
`default_nettype none

module pth_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        s_tuser,   // [1:0] operation
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic                   q_valid,
    output pth_pkg::q_entry_t      q_entry,
    input  wire logic              q_pop
);
    import pth_pkg::*;

    q_entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    q_entry_t              in_entry;
    logic                  push;

    // Classify the incoming transaction
    always_comb begin
        in_entry.data = s_tdata;
        unique case (s_tuser)
            OP_PULSE: in_entry.kind = KIND_PULSE;
            OP_TICK:  in_entry.kind = KIND_TICK;
            OP_BYTE:  in_entry.kind = KIND_BYTE;
            default:  in_entry.kind = KIND_NONE;
        endcase
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/pth_median.sv =====
`default_nettype none

module pth_median #(
    parameter int WINDOW_DEPTH = 9,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [COUNT_WIDTH-1:0] win [WINDOW_DEPTH],
    output logic                        done,
    output logic [COUNT_WIDTH-1:0]      median
);
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int MID   = (WINDOW_DEPTH - 1) / 2;

    logic                    busy_reg;
    logic                    checking_reg;
    logic                    done_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [WINDOW_DEPTH-1:0] lt_vec_reg, le_vec_reg;
    logic [COUNT_WIDTH-1:0]  cand_reg;
    logic [COUNT_WIDTH-1:0]  median_reg;
    logic [WINDOW_DEPTH-1:0] lt_cmp, le_cmp;
    logic [CNT_W-1:0]        lt_cnt, le_cnt;
    logic                    hit;

    // Rank the candidate against every entry of the window
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            lt_cmp[i] = win[i] <  win[idx_reg];
            le_cmp[i] = win[i] <= win[idx_reg];
        end
    end

    assign lt_cnt = CNT_W'($countones(lt_vec_reg));
    assign le_cnt = CNT_W'($countones(le_vec_reg));
    // The candidate is the median when it can sit at the middle sorted place
    assign hit    = (lt_cnt <= CNT_W'(MID)) && (le_cnt > CNT_W'(MID));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            checking_reg <= 1'b0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg     <= 1'b1;
                checking_reg <= 1'b0;
                idx_reg      <= '0;
            end else if (busy_reg && !checking_reg) begin
                checking_reg <= 1'b1;
            end else if (busy_reg) begin
                checking_reg <= 1'b0;
                if (hit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !checking_reg) begin
            lt_vec_reg <= lt_cmp;
            le_vec_reg <= le_cmp;
            cand_reg   <= win[idx_reg];
        end
        if (busy_reg && checking_reg && hit) begin
            median_reg <= cand_reg;
        end
    end

    assign done   = done_reg;
    assign median = median_reg;

endmodule

`default_nettype wire

// ===== src/pth_back.sv =====
`default_nettype none

module pth_back #(
    parameter int WINDOW_DEPTH = 9,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              q_valid,
    input  wire pth_pkg::q_entry_t q_entry,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic [0:0]             m_tuser,
    output logic                   m_tlast
);
    import pth_pkg::*;

    localparam int CMP_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int DIFF_W = (COUNT_WIDTH > 10) ? COUNT_WIDTH : 10;
    localparam int PROD_W = DIFF_W + 3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MEDIAN = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_REPLY  = 4'b1000
    } back_state_t;

    function automatic logic heater_rule(input logic allowed, input logic on,
                                         input logic [CMP_W-1:0] med,
                                         input logic [CMP_W-1:0] sp,
                                         input logic [CMP_W-1:0] band);
        logic r;
        r = on;
        if (allowed) begin
            if (on && med >= sp) begin
                r = 1'b0;
            end else if (!on && sp > band && med < sp - band) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    back_state_t            state_reg, state_next;
    logic [15:0]            gap_ticks_reg, gap_ticks_next;
    logic [7:0]             band_reg, band_next;
    logic [COUNT_WIDTH-1:0] pulse_count_reg, pulse_count_next;
    logic [15:0]            gap_timer_reg, gap_timer_next;
    logic                   gap_running_reg, gap_running_next;
    logic [COUNT_WIDTH-1:0] win_reg [WINDOW_DEPTH];
    logic [COUNT_WIDTH-1:0] win_next [WINDOW_DEPTH];
    logic [COUNT_WIDTH-1:0] median_reg, median_next;
    logic [15:0]            setpoint_reg, setpoint_next;
    logic                   heater_reg, heater_next;
    logic                   allowed_reg, allowed_next;
    logic                   armed_reg, armed_next;
    logic                   expect_high_reg, expect_high_next;
    logic [DIFF_W-1:0]      mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [7:0]             hi_byte_reg, hi_byte_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                   out_free;
    logic                   emit;
    logic                   e_tx_valid;
    logic [7:0]             e_tx_byte;
    logic                   e_last;
    logic                   med_start;
    logic                   med_done;
    logic [COUNT_WIDTH-1:0] med_value;
    logic [15:0]            timer_inc;
    logic [15:0]            gap_limit;
    logic [DIFF_W-1:0]      med_wide;
    logic [PROD_W-1:0]      cel_prod;
    logic [15:0]            cel_q;
    logic [15:0]            cel_word;

    pth_median #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (med_start),
        .win     (win_reg),
        .done    (med_done),
        .median  (med_value)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign timer_inc = gap_timer_reg + 16'd1;
    assign gap_limit = (gap_ticks_reg == 16'd0) ? 16'd1 : gap_ticks_reg;
    assign med_wide  = DIFF_W'(median_reg);

    // Celsius: 5 * |median - offset| + 4, divided by 8, sign put back
    assign cel_prod  = {1'b0, mag_reg, 2'b00} + {3'b000, mag_reg} + PROD_W'(4);
    assign cel_q     = 16'(cel_prod[PROD_W-1:3]);
    assign cel_word  = neg_reg ? (~cel_q + 16'd1) : cel_q;

    always_comb begin
        state_next       = state_reg;
        gap_ticks_next   = gap_ticks_reg;
        band_next        = band_reg;
        pulse_count_next = pulse_count_reg;
        gap_timer_next   = gap_timer_reg;
        gap_running_next = gap_running_reg;
        win_next         = win_reg;
        median_next      = median_reg;
        setpoint_next    = setpoint_reg;
        heater_next      = heater_reg;
        allowed_next     = allowed_reg;
        armed_next       = armed_reg;
        expect_high_next = expect_high_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        hi_byte_next     = hi_byte_reg;
        q_pop            = 1'b0;
        med_start        = 1'b0;
        emit             = 1'b0;
        e_tx_valid       = 1'b0;
        e_tx_byte        = 8'd0;
        e_last           = 1'b1;

        if (cfg_we) begin
            case (cfg_index)
                REG_GAP_TICKS: gap_ticks_next = cfg_wdata;
                REG_BAND:      band_next      = cfg_wdata[7:0];
                default:       gap_ticks_next = gap_ticks_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (q_entry.kind)
                        KIND_PULSE: begin
                            pulse_count_next = pulse_count_reg + 1'b1;
                            gap_timer_next   = 16'd0;
                            gap_running_next = 1'b1;
                        end
                        KIND_TICK: begin
                            if (gap_running_reg) begin
                                if (timer_inc >= gap_limit) begin
                                    gap_running_next = 1'b0;
                                    gap_timer_next   = 16'd0;
                                    pulse_count_next = '0;
                                    if (pulse_count_reg != '0) begin
                                        // Shift the burst in, rank later
                                        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
                                            win_next[i] = win_reg[i-1];
                                        end
                                        win_next[0] = pulse_count_reg;
                                        med_start   = 1'b1;
                                        emit        = 1'b0;
                                        state_next  = ST_MEDIAN;
                                    end else begin
                                        heater_next = heater_rule(allowed_reg, heater_reg,
                                            CMP_W'(median_reg), CMP_W'(setpoint_reg),
                                            CMP_W'(band_reg));
                                    end
                                end else begin
                                    gap_timer_next = timer_inc;
                                end
                            end
                        end
                        KIND_BYTE: begin
                            if (armed_reg && expect_high_reg) begin
                                setpoint_next    = {q_entry.data, setpoint_reg[7:0]};
                                allowed_next     = 1'b1;
                                armed_next       = 1'b0;
                                expect_high_next = 1'b0;
                                heater_next = heater_rule(1'b1, heater_reg,
                                    CMP_W'(median_reg),
                                    CMP_W'({q_entry.data, setpoint_reg[7:0]}),
                                    CMP_W'(band_reg));
                            end else if (armed_reg) begin
                                allowed_next     = 1'b0;
                                setpoint_next    = {8'd0, q_entry.data};
                                expect_high_next = 1'b1;
                            end else if (q_entry.data == RX_ARM_CODE) begin
                                armed_next       = 1'b1;
                                expect_high_next = 1'b0;
                            end else if (q_entry.data == RX_REPLY_CODE) begin
                                e_tx_valid   = 1'b1;
                                e_tx_byte    = cel_word[7:0];
                                e_last       = 1'b0;
                                hi_byte_next = cel_word[15:8];
                                state_next   = ST_REPLY;
                            end
                        end
                        KIND_NONE: begin
                            emit = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_MEDIAN: begin
                if (med_done) begin
                    median_next = med_value;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Refresh the Celsius operands from the new median
                if (med_wide >= DIFF_W'(CEL_OFFSET)) begin
                    mag_next = med_wide - DIFF_W'(CEL_OFFSET);
                    neg_next = 1'b0;
                end else begin
                    mag_next = DIFF_W'(CEL_OFFSET) - med_wide;
                    neg_next = 1'b1;
                end
                if (out_free) begin
                    emit        = 1'b1;
                    heater_next = heater_rule(allowed_reg, heater_reg,
                        CMP_W'(median_reg), CMP_W'(setpoint_reg), CMP_W'(band_reg));
                    state_next  = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_tx_valid = 1'b1;
                    e_tx_byte  = hi_byte_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, e_tx_byte, 16'(median_next), allowed_next, heater_next};
            m_tuser_next  = e_tx_valid;
            m_tlast_next  = e_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            gap_ticks_reg   <= GAP_TICKS_RESET;
            band_reg        <= BAND_RESET;
            pulse_count_reg <= '0;
            gap_timer_reg   <= '0;
            gap_running_reg <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            median_reg      <= '0;
            setpoint_reg    <= 16'd1;
            heater_reg      <= 1'b0;
            allowed_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            expect_high_reg <= 1'b0;
            mag_reg         <= DIFF_W'(CEL_OFFSET);
            neg_reg         <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            gap_ticks_reg   <= gap_ticks_next;
            band_reg        <= band_next;
            pulse_count_reg <= pulse_count_next;
            gap_timer_reg   <= gap_timer_next;
            gap_running_reg <= gap_running_next;
            win_reg         <= win_next;
            median_reg      <= median_next;
            setpoint_reg    <= setpoint_next;
            heater_reg      <= heater_next;
            allowed_reg     <= allowed_next;
            armed_reg       <= armed_next;
            expect_high_reg <= expect_high_next;
            mag_reg         <= mag_next;
            neg_reg         <= neg_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_byte_reg <= hi_byte_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// ===== src/pulse_thermostat_median_hysteresis.sv =====
// Pulse-counting thermostat with a median filter and a hysteresis heater rule.
// Input stream: one transaction per event. s_tuser carries the operation
// (pulse edge, timer tick, serial byte), s_tdata the received serial byte.
// Output stream: one transaction per input event, two for a Celsius reply
// (low byte, then high byte with m_tlast set). Every output transaction
// carries heater state, heater enable and the current window median.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 gap_ticks, 1 hysteresis_band); write only while the block is idle.
// Throughput: one item per cycle for pulses, ticks and bytes while the output
// is not stalled; a reply sends its second output transaction before the next
// item is taken. A tick that ends a nonzero burst holds further items until
// the median unit, which ranks one candidate entry at a time against the whole window, is done.
// A two-entry queue sits between the input side and the execution side, and
// the output register lets a result wait while the next item is accepted.
// Reset (aresetn low, synchronous) clears counts, window, median, setpoint
// (to one), heater and receiver state, and reloads the register defaults.
// When the receiver stalls, the output holds, the queue fills and s_tready
// drops; no transaction is lost.
`default_nettype none

module pulse_thermostat_median_hysteresis #(
    parameter int WINDOW_DEPTH = 9,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [0] heater_drive, [1] heater_enabled,
                                        // [17:2] median_count, [25:18] tx_byte,
                                        // [31:26] zero
    output logic [0:0]       m_tuser,   // [0] tx_valid
    output logic             m_tlast    // last
);
    import pth_pkg::*;

    logic     q_valid;
    q_entry_t q_entry;
    logic     q_pop;

    // Accept and classify transactions, hold them in the queue
    pth_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // Execute queued items and drive the result register
    pth_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
